// ===== design/psrf_pkg.sv =====
// Package for the packet slot ring FIFO: default sizes, field widths, op and status
// codes, and the control word that goes from the front end through the command queue.
// No dependencies.
package psrf_pkg;

   // Default sizes handed to the top level.
   localparam int SLOTS_DEFAULT       = 16;
   localparam int SLOT_BYTES_DEFAULT  = 2048;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Fixed field widths.
   localparam int BYTE_W  = 8;
   localparam int LIMIT_W = 12;
   localparam int USED_W  = 4;

   localparam logic [LIMIT_W-1:0] READ_LIMIT_RESET = 12'd2048;

   // Operation codes of an input item.
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_DROP  = 2'd2,
      ST_TRUNC = 2'd3
   } psrf_status_type;

   // Control part of one command for the back end.
   typedef struct packed {
      logic                mem_read;
      logic                mem_write;
      logic                read_last;
      psrf_status_type     status;
      logic [USED_W-1:0]   slots_used;
   } psrf_ctl_type;

endpackage

// ===== design/psrf_front.sv =====
// Front end of the packet slot ring FIFO: accepts items, keeps the ring
// pointers, offsets and packet lengths, and issues one command per item.
// Depends on psrf_pkg.
module psrf_front
   import psrf_pkg::*;
#(
   parameter int SLOTS      = SLOTS_DEFAULT,
   parameter int SLOT_BYTES = SLOT_BYTES_DEFAULT,
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int LW = $clog2(SLOT_BYTES + 1),
   localparam int AW = $clog2(SLOTS * SLOT_BYTES)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [BYTE_W-1:0]  req_write_byte,
   input  logic               req_last_byte,
   input  logic               csr_write_enable,
   input  logic [LIMIT_W-1:0] csr_write_data,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output psrf_ctl_type       cmd_ctl,
   output logic [AW-1:0]      cmd_addr,
   output logic [BYTE_W-1:0]  cmd_data
);

   localparam int CW = (LW + 1 > LIMIT_W) ? LW + 1 : LIMIT_W;
   localparam int UW = (SW > USED_W) ? SW : USED_W;

   logic [SW-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [LW-1:0]      woff_ff, woff_in, roff_ff, roff_in;
   logic               drop_ff, drop_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic               len_stale_ff;
   logic [LW-1:0]      len_rd_ff;
   logic [LW-1:0]      len_mem [SLOTS];

   logic               accept;
   logic [SW-1:0]      tail_next, head_next;
   logic               commit;
   logic [LW-1:0]      woff_after;
   logic [CW-1:0]      lim, len_ext, eff, roff_inc;
   logic               pop_last;
   logic [SW-1:0]      used;
   logic [UW-1:0]      used_ext;

   // A packet committed into the head slot cannot have its length read back until
   // len_rd_ff is refreshed, so intake pauses while len_stale_ff is set.
   assign cmd_valid = req_valid && !len_stale_ff;
   assign req_ready = cmd_ready && !len_stale_ff;
   assign accept    = req_valid && req_ready;

   assign tail_next = (tail_ff == SW'(SLOTS - 1)) ? '0 : tail_ff + SW'(1);
   assign head_next = (head_ff == SW'(SLOTS - 1)) ? '0 : head_ff + SW'(1);

   // Effective read length of the head packet and end-of-read test.
   always_comb begin
      lim      = (limit_ff == '0) ? CW'(1) : CW'(limit_ff);
      len_ext  = CW'(len_rd_ff);
      eff      = (len_ext < lim) ? len_ext : lim;
      roff_inc = CW'(roff_ff) + CW'(1);
      pop_last = (roff_inc >= eff);
   end

   // Classify the item, build its command and the next pointer state.
   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      woff_in    = woff_ff;
      roff_in    = roff_ff;
      drop_in    = drop_ff;
      commit     = 1'b0;
      woff_after = woff_ff;
      cmd_ctl            = '0;
      cmd_ctl.status     = ST_OK;
      cmd_addr           = '0;
      cmd_data           = req_write_byte;
      if (req_op == OP_PUSH) begin
         cmd_addr = AW'(tail_ff) * AW'(SLOT_BYTES) + AW'(woff_ff);
         if (drop_ff || (woff_ff == '0 && tail_next == head_ff)) begin
            cmd_ctl.status = ST_DROP;
            drop_in        = !req_last_byte;
         end else begin
            if (woff_ff < LW'(SLOT_BYTES)) begin
               cmd_ctl.mem_write = 1'b1;
               woff_after        = woff_ff + LW'(1);
            end else begin
               cmd_ctl.status = ST_TRUNC;
            end
            woff_in = woff_after;
            if (req_last_byte) begin
               commit  = 1'b1;
               tail_in = tail_next;
               woff_in = '0;
            end
         end
      end else if (head_ff == tail_ff) begin
         cmd_ctl.status = ST_EMPTY;
      end else begin
         cmd_ctl.mem_read = 1'b1;
         cmd_addr         = AW'(head_ff) * AW'(SLOT_BYTES) + AW'(roff_ff);
         if (pop_last) begin
            cmd_ctl.read_last = 1'b1;
            roff_in           = '0;
            head_in           = head_next;
         end else begin
            roff_in = roff_ff + LW'(1);
         end
      end
      if (!accept) begin
         head_in = head_ff;
         tail_in = tail_ff;
         woff_in = woff_ff;
         roff_in = roff_ff;
         drop_in = drop_ff;
         commit  = 1'b0;
      end
      // Committed packets after this item, modulo the ring size.
      if (tail_in >= head_in) begin
         used = tail_in - head_in;
      end else begin
         used = tail_in + SW'(SLOTS) - head_in;
      end
      used_ext           = UW'(used);
      cmd_ctl.slots_used = used_ext[USED_W-1:0];
   end

   // Pointer, offset and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         woff_ff      <= '0;
         roff_ff      <= '0;
         drop_ff      <= 1'b0;
         limit_ff     <= READ_LIMIT_RESET;
         len_stale_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         woff_ff      <= woff_in;
         roff_ff      <= roff_in;
         drop_ff      <= drop_in;
         len_stale_ff <= commit && (tail_ff == head_in);
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
      end
   end

   // Packet length memory: written at the tail, read at the next head.
   always_ff @(posedge clock) begin
      if (commit) begin
         len_mem[tail_ff] <= woff_after;
      end
      len_rd_ff <= len_mem[head_in];
   end

endmodule

// ===== design/psrf_queue.sv =====
// Small command queue between the front and back ends of the ring FIFO.
// Depends on psrf_pkg for its default depth.
module psrf_queue
   import psrf_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int NW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0]    count_ff;
   logic             push, pop;

   assign in_ready  = (count_ff != NW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + NW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - NW'(1);
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== design/psrf_back.sv =====
// Back end of the ring FIFO: the single-port packet byte memory and the
// registered result stage.
// Depends on psrf_pkg.
module psrf_back
   import psrf_pkg::*;
#(
   parameter int SLOTS      = SLOTS_DEFAULT,
   parameter int SLOT_BYTES = SLOT_BYTES_DEFAULT,
   localparam int AW = $clog2(SLOTS * SLOT_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  psrf_ctl_type      cmd_ctl,
   input  logic [AW-1:0]     cmd_addr,
   input  logic [BYTE_W-1:0] cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_read_byte,
   output logic              rsp_read_last,
   output logic [1:0]        rsp_status,
   output logic [USED_W-1:0] rsp_slots_used
);

   logic [BYTE_W-1:0] store_mem [SLOTS * SLOT_BYTES];
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_last_ff;
   psrf_status_type   rsp_status_ff;
   logic [USED_W-1:0] rsp_used_ff;
   logic              load;

   // A command executes when the result register is free or being emptied.
   assign load      = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign cmd_ready = load;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_byte  = rsp_byte_ff;
   assign rsp_read_last  = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slots_used = rsp_used_ff;

   // Result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Memory access; the read data lands directly in the result register.
   always_ff @(posedge clock) begin
      if (load) begin
         if (cmd_ctl.mem_write) begin
            store_mem[cmd_addr] <= cmd_data;
         end
         if (cmd_ctl.mem_read) begin
            rsp_byte_ff <= store_mem[cmd_addr];
         end else begin
            rsp_byte_ff <= '0;
         end
         rsp_last_ff   <= cmd_ctl.read_last;
         rsp_status_ff <= cmd_ctl.status;
         rsp_used_ff   <= cmd_ctl.slots_used;
      end
   end

endmodule

// ===== design/packet_slot_ring_fifo.sv =====
// Top level of the packet slot ring FIFO: front end, command queue and back end.
// Depends on psrf_pkg, psrf_front, psrf_queue and psrf_back.
//
//   Channel   Ports   Direction  Moves
//   request   req_    in         one push byte or one pop per transfer
//   response  rsp_    out        one result per request transfer
//   control   csr_    in         read_limit write, taken at once
//
// One request per cycle is taken in steady state while the command queue has room;
// a result is registered after its request passes queue entry, then memory access.
// After a packet is committed into the slot at the head of the ring, intake
// pauses while the length memory read is refreshed.
// Reset is synchronous and clears pointers and queue; the byte and length
// memories need no clearing pass. A stalled response holds the back end; the
// front end keeps taking requests until the command queue is full.
module packet_slot_ring_fifo
   import psrf_pkg::*;
#(
   parameter int SLOTS       = SLOTS_DEFAULT,
   parameter int SLOT_BYTES  = SLOT_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [BYTE_W-1:0]  req_write_byte,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [BYTE_W-1:0]  rsp_read_byte,
   output logic               rsp_read_last,
   output logic [1:0]         rsp_status,
   output logic [USED_W-1:0]  rsp_slots_used,
   input  logic               csr_write_enable,
   input  logic [LIMIT_W-1:0] csr_write_data
);

   localparam int AW = $clog2(SLOTS * SLOT_BYTES);
   localparam int QW = $bits(psrf_ctl_type) + AW + BYTE_W;

   logic              fe_valid, fe_ready;
   psrf_ctl_type      fe_ctl;
   logic [AW-1:0]     fe_addr;
   logic [BYTE_W-1:0] fe_data;
   logic              be_valid, be_ready;
   psrf_ctl_type      be_ctl;
   logic [AW-1:0]     be_addr;
   logic [BYTE_W-1:0] be_data;
   logic [QW-1:0]     q_in, q_out;

   psrf_front #(
      .SLOTS      (SLOTS),
      .SLOT_BYTES (SLOT_BYTES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_write_byte   (req_write_byte),
      .req_last_byte    (req_last_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd_valid        (fe_valid),
      .cmd_ready        (fe_ready),
      .cmd_ctl          (fe_ctl),
      .cmd_addr         (fe_addr),
      .cmd_data         (fe_data)
   );

   // Commands travel through the queue as one flat word.
   assign q_in = {fe_ctl, fe_addr, fe_data};
   assign {be_ctl, be_addr, be_data} = q_out;

   psrf_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_ready  (fe_ready),
      .in_data   (q_in),
      .out_valid (be_valid),
      .out_ready (be_ready),
      .out_data  (q_out)
   );

   psrf_back #(
      .SLOTS      (SLOTS),
      .SLOT_BYTES (SLOT_BYTES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (be_valid),
      .cmd_ready      (be_ready),
      .cmd_ctl        (be_ctl),
      .cmd_addr       (be_addr),
      .cmd_data       (be_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_read_last  (rsp_read_last),
      .rsp_status     (rsp_status),
      .rsp_slots_used (rsp_slots_used)
   );

endmodule

// ===== design/psrf_checker.sv =====
// Port-level checks for the packet slot ring FIFO, bound to the top level.
// Depends on psrf_pkg and packet_slot_ring_fifo.
module psrf_checker
   import psrf_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_op,
   input logic [BYTE_W-1:0]  req_write_byte,
   input logic               req_last_byte,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [BYTE_W-1:0]  rsp_read_byte,
   input logic               rsp_read_last,
   input logic [1:0]         rsp_status,
   input logic [USED_W-1:0]  rsp_slots_used
);

   // A waiting request holds its valid and payload until the transfer.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_op) &&
      $stable(req_write_byte) && $stable(req_last_byte))
      else $error("waiting request changed");

   // A stalled result holds its valid and payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_byte) &&
      $stable(rsp_read_last) && $stable(rsp_status) && $stable(rsp_slots_used))
      else $error("stalled response changed");

   // Results with a status other than ok (dropped or truncated pushes and empty pops) return no byte and no packet end.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_read_byte == '0) && !rsp_read_last)
      else $error("non-ok result carries read data");

   // The end of a packet is only reported by a successful pop.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_last |-> (rsp_status == ST_OK))
      else $error("packet end with error status");

   // No result is offered right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind packet_slot_ring_fifo psrf_checker u_checker (.*);
